// File: design/assert_macros.svh
// assertion macros used by the encoder frame checker controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define EFC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("efc assertion failed");
// checked at every edge, reset included
`define EFC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("efc assertion failed");
`else
`define EFC_ASSERT(lbl, clk, rst, prop)
`define EFC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: design/efc_pkg.sv
// types, constants and crc function for the encoder frame checker
package efc_pkg;

  localparam int ANGLE_FRAC_BITS = 16;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 18;
  localparam int MT_W      = 16;
  localparam int ANGLE_W   = 25;
  localparam int CODE_W    = 2;
  localparam int RES_W     = 19;
  localparam int COUNT_W   = 3;
  localparam int FRAME_W   = 40;
  localparam int DEG_W     = 9;
  localparam int PROD_W    = POS_W + DEG_W;
  localparam int NUM_W     = PROD_W + ANGLE_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [BYTE_W-1:0]  CRC_POLY     = 8'h97;
  localparam logic [BYTE_W-1:0]  STATUS_MASK  = 8'h02;
  localparam logic [BYTE_W-1:0]  CRC_INVERT   = 8'hFF;
  localparam int                 POS_SHIFT    = 6;
  localparam logic [DEG_W-1:0]   DEG_FULL     = 9'd360;
  localparam logic [RES_W-1:0]   RES_RESET    = 19'd262144;
  localparam logic [COUNT_W-1:0] LAST_DATA    = 3'd5;
  localparam logic [NUM_W-1:0]   ANGLE_FULL   = NUM_W'(DEG_FULL) << ANGLE_FRAC_BITS;

  localparam logic [CODE_W-1:0] CODE_OK     = 2'd0;
  localparam logic [CODE_W-1:0] CODE_CRC    = 2'd1;
  localparam logic [CODE_W-1:0] CODE_STATUS = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [MT_W-1:0]    multiturn;
    logic [ANGLE_W-1:0] angle_q16;
    logic [CODE_W-1:0]  result_code;
    logic [BYTE_W-1:0]  computed_crc;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic final_byte;
  } status_t;

  // msb-first crc-8, one byte
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/encoder_frame_checker.sv
// top level of the encoder frame checker: controller and datapath
//
// Takes an absolute encoder's six-byte SPI frame one byte per item (frame_start
// marks byte 0 and drops any partial frame), runs an msb-first CRC-8 (poly 0x97,
// init 0) over bytes 0 to 4 and checks its inverse against byte 5. After the
// sixth byte one result item comes out with multiturn, the 18-bit position, the
// angle position*360/angle_resolution in unsigned Q.16 degrees saturated at 360
// (zero on any error, full scale for a zero resolution), the status code and the
// computed crc. Bytes 0 to 4 are taken back to back while idle. The sixth byte
// first captures the frame, then a restoring divider yields one quotient bit a
// cycle over the 27 + ANGLE_FRAC_BITS bit numerator, then the output register
// is loaded; in_ready is low meanwhile, and also while a previous result still
// sits in the output register unread at that point. Bytes of the next frame are
// taken while a result waits. angle_resolution is written through cfg_we and
// cfg_wdata; the user must do so only while the block is idle, which the block
// itself does not enforce. Its reset value is 262144.
module encoder_frame_checker import efc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // byte items in
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_item,
  // result items out
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_item,
  // resolution register
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_wdata
);

  // command and status between controller and datapath
  cmd_t    cmd;
  status_t sts;

  // sequencing: intake, divide steps, output handoff
  efc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // crc, frame bytes, divider and the result register
  efc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

// File: design/efc_ctrl.sv
// controller state machine: byte intake, divide sequencing, result handoff
`include "assert_macros.svh"

module efc_ctrl import efc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]           state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;

  assign in_ready     = (state == S_IDLE);
  assign cmd.take     = in_valid && in_ready;
  assign cmd.div_step = (state == S_DIV);
  assign cmd.load_out = (state == S_WAIT) && (!out_valid || out_ready);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    case (state)
      S_IDLE: begin
        if (cmd.take && sts.final_byte) begin
          state_next   = S_DIV;
          div_cnt_next = DIV_CNT_W'(NUM_W - 1);
        end
      end
      S_DIV: begin
        if (div_cnt == '0) begin
          state_next = S_WAIT;
        end else begin
          div_cnt_next = div_cnt - 1'b1;
        end
      end
      S_WAIT: begin
        if (cmd.load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `EFC_ASSERT(a_final_starts_div, clk, rst, cmd.take && sts.final_byte |=> state == S_DIV)
  `EFC_ASSERT(a_div_ends_in_wait, clk, rst, state == S_DIV && div_cnt == '0 |=> state == S_WAIT)
  `EFC_ASSERT(a_rise_from_load, clk, rst, $rose(out_valid) |-> $past(state) == S_WAIT)
  `EFC_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid && state == S_IDLE)

endmodule

// File: design/efc_datapath.sv
// datapath: crc, frame assembly, restoring divider, result register
module efc_datapath import efc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  in_t              in_item,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_wdata,
  input  cmd_t             cmd,
  output status_t          sts,
  output out_t             out_item
);

  logic [COUNT_W-1:0] byte_count;
  logic [BYTE_W-1:0]  crc_acc;
  logic [FRAME_W-1:0] frame_bytes;
  logic [RES_W-1:0]   resolution;

  logic [POS_W-1:0]   pos_r;
  logic [MT_W-1:0]    mt_r;
  logic [CODE_W-1:0]  code_r;
  logic [BYTE_W-1:0]  calc_r;
  logic [NUM_W-1:0]   num;
  logic [RES_W-1:0]   rem;

  logic [COUNT_W-1:0] count_eff;
  logic [BYTE_W-1:0]  crc_eff;
  logic [FRAME_W-1:0] frame_eff;
  logic [BYTE_W-1:0]  calc;
  logic [POS_W-1:0]   pos;
  logic [PROD_W-1:0]  prod;
  logic [CODE_W-1:0]  code;
  logic [RES_W:0]     trial;
  logic               q_bit;
  logic [NUM_W-1:0]   angle_sat;

  // frame_start restarts from a cleared frame
  assign count_eff = in_item.frame_start ? '0 : byte_count;
  assign crc_eff   = in_item.frame_start ? '0 : crc_acc;
  assign frame_eff = in_item.frame_start ? '0 : frame_bytes;

  assign sts.final_byte = (count_eff >= LAST_DATA);

  assign calc = crc_eff ^ CRC_INVERT;
  assign pos  = frame_eff[POS_SHIFT +: POS_W];
  assign prod = PROD_W'(pos) * PROD_W'(DEG_FULL);

  always_comb begin
    if (calc != in_item.rx_byte) begin
      code = CODE_CRC;
    end else if ((frame_eff[15:8] & STATUS_MASK) == '0) begin
      code = CODE_STATUS;
    end else begin
      code = CODE_OK;
    end
  end

  // one quotient bit per step
  assign trial = {rem, num[NUM_W-1]};
  assign q_bit = (trial >= {1'b0, resolution});

  assign angle_sat = (num > ANGLE_FULL) ? ANGLE_FULL : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      crc_acc     <= '0;
      frame_bytes <= '0;
      resolution  <= RES_RESET;
    end else begin
      if (cfg_we) begin
        resolution <= cfg_wdata;
      end
      if (cmd.take) begin
        if (sts.final_byte) begin
          byte_count  <= '0;
          crc_acc     <= '0;
          frame_bytes <= '0;
        end else begin
          byte_count  <= count_eff + 1'b1;
          crc_acc     <= crc8_update(crc_eff, in_item.rx_byte);
          frame_bytes <= {frame_eff[FRAME_W-BYTE_W-1:0], in_item.rx_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && sts.final_byte) begin
      pos_r  <= pos;
      mt_r   <= frame_eff[FRAME_W-1 -: MT_W];
      code_r <= code;
      calc_r <= calc;
      num    <= {prod, {ANGLE_FRAC_BITS{1'b0}}};
      rem    <= '0;
    end else if (cmd.div_step) begin
      num <= {num[NUM_W-2:0], q_bit};
      rem <= q_bit ? RES_W'(trial - {1'b0, resolution}) : trial[RES_W-1:0];
    end
    if (cmd.load_out) begin
      out_item.position     <= pos_r;
      out_item.multiturn    <= mt_r;
      out_item.angle_q16    <= (code_r == CODE_OK) ? angle_sat[ANGLE_W-1:0] : '0;
      out_item.result_code  <= code_r;
      out_item.computed_crc <= calc_r;
    end
  end

endmodule

// File: tb/tb_encoder_frame_checker.sv
// testbench for the encoder frame checker: directed table, random frames, predictor check
`timescale 1ns / 100ps

module tb_encoder_frame_checker;
  import efc_pkg::*;

  // no-handshake cycles before the run is declared hung; the divide on the sixth
  // byte and the stalls on either side pass with no handshake
  localparam int HANG_LIMIT   = 3000;
  // settle time before a register write and at the end, above the divide latency
  localparam int SETTLE_CYC   = 60;
  localparam int PHASE_ITEMS  = 190;
  localparam int NUM_PHASES   = 7;

  // where the byte of a directed row comes from
  typedef enum logic [1:0] {
    BYTE_AS_IS,
    BYTE_GOOD_CRC,
    BYTE_BAD_CRC
  } byte_src_e;

  typedef struct {
    byte_src_e   src;
    logic [7:0]  value;
    logic        start;
    bit          typed;
    out_t        result;
  } step_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_t              in_item;
  logic             out_valid;
  logic             out_ready;
  out_t             out_item;
  logic             cfg_we;
  logic [RES_W-1:0] cfg_wdata;

  // predictor copy of the frame state and the resolution register
  logic [COUNT_W-1:0] fr_count;
  logic [BYTE_W-1:0]  fr_crc;
  logic [FRAME_W-1:0] fr_bytes;
  logic [RES_W-1:0]   fr_res;

  out_t expected_results[$];
  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  int   bytes_sent     = 0;

  // directed table; only the obvious results are typed in, the rest
  // come from the predictor
  step_row_t directed_rows [0:24] = '{
    // all-zero frame right after reset: crc fine, status bit clear
    '{BYTE_AS_IS, 8'h00, 1'b1, 1'b0, '0},
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'hFF, 1'b0, 1'b1, '{18'd0, 16'd0, 25'd0, CODE_STATUS, 8'hFF}},
    // zero frame again with no frame_start, bad crc and clear status: crc wins
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h00, 1'b0, 1'b1, '{18'd0, 16'd0, 25'd0, CODE_CRC, 8'hFF}},
    // one stray byte, then a restart that drops it
    '{BYTE_AS_IS, 8'h5A, 1'b1, 1'b0, '0},
    // all-ones frame, good crc: top position and turn count
    '{BYTE_AS_IS, 8'hFF, 1'b1, 1'b0, '0},
    '{BYTE_AS_IS, 8'hFF, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'hFF, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'hFF, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'hFF, 1'b0, 1'b0, '0},
    '{BYTE_GOOD_CRC, 8'h00, 1'b0, 1'b0, '0},
    // status set but crc off by one bit
    '{BYTE_AS_IS, 8'h00, 1'b1, 1'b0, '0},
    '{BYTE_AS_IS, 8'h01, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h80, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h02, 1'b0, 1'b0, '0},
    '{BYTE_AS_IS, 8'h40, 1'b0, 1'b0, '0},
    '{BYTE_BAD_CRC, 8'h00, 1'b0, 1'b0, '0}
  };

  encoder_frame_checker DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // msb-first crc-8 over one byte
  function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ 8'h97) : (c << 1);
    end
    return c;
  endfunction

  task automatic drop_frame();
    fr_count = '0;
    fr_crc   = '0;
    fr_bytes = '0;
  endtask

  // advance the frame state by one byte; done is set on the sixth byte
  task automatic take_byte(input in_t it, output bit done, output out_t res);
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] inv_crc;
    logic [CODE_W-1:0] code;
    logic [63:0]       scaled;
    logic [63:0]       full_scale;
    done = 1'b0;
    res  = '0;
    if (it.frame_start) drop_frame();
    if (fr_count < 3'd5) begin
      fr_crc   = crc_next(fr_crc, it.rx_byte);
      fr_bytes = {fr_bytes[FRAME_W-9:0], it.rx_byte};
      fr_count = fr_count + 3'd1;
    end else begin
      inv_crc    = ~fr_crc;
      pos        = fr_bytes[23:6];
      full_scale = 64'd360 << ANGLE_FRAC_BITS;
      // crc mismatch beats a clear status bit
      if (inv_crc != it.rx_byte) code = CODE_CRC;
      else if (!fr_bytes[9])     code = CODE_STATUS;
      else                       code = CODE_OK;
      if (code != CODE_OK) begin
        scaled = '0;
      end else if (fr_res == '0) begin
        scaled = full_scale;
      end else begin
        scaled = ((64'(pos) * 64'd360) << ANGLE_FRAC_BITS) / 64'(fr_res);
        if (scaled > full_scale) scaled = full_scale;
      end
      res.position     = pos;
      res.multiturn    = fr_bytes[39:24];
      res.angle_q16    = scaled[ANGLE_W-1:0];
      res.result_code  = code;
      res.computed_crc = inv_crc;
      done = 1'b1;
      drop_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // predict, then present one byte item and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic st, input int gap,
                           input bit typed, input out_t typed_res);
    in_t  it;
    bit   done;
    out_t res;
    it.rx_byte     = b;
    it.frame_start = st;
    take_byte(it, done, res);
    if (done) expected_results.push_back(typed ? typed_res : res);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // one frame of random content; most are well formed, the rest carry
  // a bad crc, a clear status bit, or get cut short
  task automatic send_random_frame();
    int          flavor;
    int          cut;
    bit          burst;
    logic        lead_start;
    logic [7:0]  data [0:4];
    logic [7:0]  check;
    flavor = $urandom_range(0, 99);
    burst  = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < 5; k++) data[k] = $urandom_range(0, 255);
    // pin the position bytes to all zeros or all ones now and then, status bit apart
    if ($urandom_range(0, 9) == 0) begin
      check   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      data[2] = check;
      data[3] = check;
      data[4] = check;
    end
    if (flavor < 80)      data[3][1] = ($urandom_range(0, 9) != 0);
    else if (flavor < 90) data[3][1] = 1'b0;
    // a frame right after a result may begin without frame_start
    lead_start = ($urandom_range(0, 4) != 0);
    if (flavor >= 90) begin
      // broken frame: a few bytes, random restarts
      cut = $urandom_range(1, 5);
      for (int k = 0; k < cut; k++) begin
        send_byte(data[k], (k == 0) ? lead_start : ($urandom_range(0, 7) == 0),
                  pick_gap(burst), 1'b0, '0);
      end
    end else begin
      for (int k = 0; k < 5; k++) begin
        send_byte(data[k], (k == 0) && lead_start, pick_gap(burst), 1'b0, '0);
      end
      check = ~fr_crc;
      if (flavor >= 70 && flavor < 80) check = check ^ (8'h01 << $urandom_range(0, 7));
      send_byte(check, 1'b0, pick_gap(burst), 1'b0, '0);
    end
  endtask

  // let every expected result drain, then give the divider time to go quiet
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_resolution(input logic [RES_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    fr_res = value;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------

  initial begin
    int hold;
    int r;
    out_ready = 1'b0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          out_ready <= 1'b1;
          hold = $urandom_range(20, 80);
        end else if (r < 70) begin
          out_ready <= 1'b1;
          hold = $urandom_range(1, 4);
        end else if (r < 92) begin
          out_ready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end else begin
        hold--;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: %p", out_item);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.position !== want.position) begin
          $error("position expected %0d got %0d", want.position, out_item.position);
          mismatch_count++;
        end
        if (out_item.multiturn !== want.multiturn) begin
          $error("multiturn expected %0d got %0d", want.multiturn, out_item.multiturn);
          mismatch_count++;
        end
        if (out_item.angle_q16 !== want.angle_q16) begin
          $error("angle_q16 expected %0d got %0d", want.angle_q16, out_item.angle_q16);
          mismatch_count++;
        end
        if (out_item.result_code !== want.result_code) begin
          $error("result_code expected %0d got %0d", want.result_code,
                 out_item.result_code);
          mismatch_count++;
        end
        if (out_item.computed_crc !== want.computed_crc) begin
          $error("computed_crc expected %0h got %0h", want.computed_crc,
                 out_item.computed_crc);
          mismatch_count++;
        end
      end
    end
  end

  // hang detector
  initial begin
    while (idle_cycles < HANG_LIMIT) @(posedge clk);
    $display("FAIL encoder_frame_checker");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [7:0]       b;
    logic [RES_W-1:0] res_plan [0:NUM_PHASES-1];
    int               phase_end;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst       = 1'b1;
    fr_res    = RES_RESET;
    drop_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows at the reset resolution
    foreach (directed_rows[i]) begin
      case (directed_rows[i].src)
        BYTE_GOOD_CRC: b = ~fr_crc;
        BYTE_BAD_CRC:  b = ~fr_crc ^ 8'h01;
        default:       b = directed_rows[i].value;
      endcase
      send_byte(b, directed_rows[i].start, $urandom_range(0, 2),
                directed_rows[i].typed, directed_rows[i].result);
    end

    // random frames under several resolutions, extremes included;
    // zero and the all-ones value lie outside the nominal range
    res_plan[0] = RES_RESET;
    res_plan[1] = 19'd1;
    res_plan[2] = 19'd0;
    res_plan[3] = 19'h7FFFF;
    res_plan[4] = 19'd360;
    res_plan[5] = $urandom_range(1, 262144);
    res_plan[6] = $urandom_range(2, 4096);
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_resolution(res_plan[p]);
      phase_end = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < phase_end) send_random_frame();
    end

    wait_idle();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS encoder_frame_checker");
    end else begin
      $display("FAIL encoder_frame_checker");
    end
    $finish;
  end

endmodule

// File: encoder_frame_checker.f
+incdir+design
design/efc_pkg.sv
design/efc_ctrl.sv
design/efc_datapath.sv
design/encoder_frame_checker.sv
tb/tb_encoder_frame_checker.sv
